// ===== hdl/hrrn_pkg.sv =====
// ----------------------------------------------------------------------------
// hrrn_pkg
// shared types and codes of the highest response ratio next ready queue
// ----------------------------------------------------------------------------
`default_nettype none

package hrrn_pkg;

    localparam int NUM_SLOTS_DEF = 16;

    localparam int ID_W     = 16;
    localparam int WAIT_W   = 24;
    localparam int SVC_W    = 16;
    localparam int SECS_W   = 16;
    localparam int COUNT_W  = 5;
    localparam int PROD_W   = WAIT_W + SVC_W;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 64;

    localparam logic [WAIT_W-1:0] WAIT_MAX = '1;

    localparam logic [1:0] CMD_PUSH   = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;
    localparam logic [1:0] CMD_SELECT = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_ZEROSVC  = 2'd3;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [WAIT_W-1:0] wait_val;
        logic [SVC_W-1:0]  svc_time;
    } slot_t;

    typedef struct packed {
        logic load_lhs;
        logic load_rhs;
    } ratio_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/hrrn_slot_mem.sv =====
// ----------------------------------------------------------------------------
// hrrn_slot_mem
// slot storage, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module hrrn_slot_mem
    import hrrn_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF,
    localparam int IDX_W = $clog2(NUM_SLOTS)
)
(
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [IDX_W-1:0] wr_addr,
    input  wire slot_t            wr_data,
    input  wire logic             rd_en,
    input  wire logic [IDX_W-1:0] rd_addr,
    output slot_t                 rd_data
);

    slot_t mem [NUM_SLOTS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/hrrn_ratio_unit.sv =====
// ----------------------------------------------------------------------------
// hrrn_ratio_unit
// shared multiplier for the cross-multiplied response ratio compare
// ----------------------------------------------------------------------------
`default_nettype none

module hrrn_ratio_unit
    import hrrn_pkg::*;
(
    input  wire logic              clk,
    input  wire ratio_ctl_t        ctl,
    input  wire logic [WAIT_W-1:0] cur_wait,
    input  wire logic [SVC_W-1:0]  cur_svc,
    input  wire logic [WAIT_W-1:0] best_wait,
    input  wire logic [SVC_W-1:0]  best_svc,
    output logic                   gt
);

    logic [WAIT_W-1:0] op_wait;
    logic [SVC_W-1:0]  op_svc;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] lhs_reg;
    logic [PROD_W-1:0] rhs_reg;

    // lhs: cur_wait * best_svc, rhs: best_wait * cur_svc
    assign op_wait = ctl.load_lhs ? cur_wait : best_wait;
    assign op_svc  = ctl.load_lhs ? best_svc : cur_svc;
    assign prod    = PROD_W'(op_wait) * PROD_W'(op_svc);

    always_ff @(posedge clk)
    begin
        if (ctl.load_lhs)
        begin
            lhs_reg <= prod;
        end
        if (ctl.load_rhs)
        begin
            rhs_reg <= prod;
        end
    end

    assign gt = lhs_reg > rhs_reg;

endmodule

`default_nettype wire

// ===== hdl/hrrn_ready_queue_unit.sv =====
// ----------------------------------------------------------------------------
// hrrn_ready_queue_unit
// highest response ratio next ready queue with push, remove, tick and select
// ----------------------------------------------------------------------------
//  channel  direction  signals                 contents
//  s        in         s_tvalid/tready/tdata   command item, cmd in s_tuser
//  m        out        m_tvalid/tready/tdata   result item, status in m_tuser
//
//  push writes its slot on accept; tick, remove and select walk the held
//  entries one slot at a time (one shared multiplier, two products per
//  slot, one slot memory read port)
//  s_tready is high only while the sequencer is idle; the result register
//  holds a finished item while the next one is taken
//  reset clears the entry count, the sequencer and the output valid flag
// ----------------------------------------------------------------------------
`default_nettype none

module hrrn_ready_queue_unit
    import hrrn_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // proc_id, service_time, initial_wait, tick_seconds
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // cmd
    input  wire logic [1:0]            s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // entry_count, is_empty, chosen_id, chosen_wait, chosen_service, zero pad
    output logic [OUT_DATA_W-1:0]      m_tdata,
    // status
    output logic [1:0]                 m_tuser
);

    localparam int IDX_W = $clog2(NUM_SLOTS);
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_REM_CHK = 4'd1;
    localparam logic [3:0] S_SH_WR   = 4'd2;
    localparam logic [3:0] S_TCK_WR  = 4'd3;
    localparam logic [3:0] S_SEL_CUR = 4'd4;
    localparam logic [3:0] S_SEL_LHS = 4'd5;
    localparam logic [3:0] S_SEL_RHS = 4'd6;
    localparam logic [3:0] S_SEL_CMP = 4'd7;
    localparam logic [3:0] S_DONE    = 4'd8;

    logic [3:0]            state_reg, state_next;
    logic [CNT_W-1:0]      occ_reg, occ_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic [1:0]            cmd_reg, cmd_next;
    logic [ID_W-1:0]       pid_reg, pid_next;
    logic [SECS_W-1:0]     secs_reg, secs_next;
    logic [1:0]            status_reg, status_next;
    slot_t                 cur_reg, cur_next;
    slot_t                 best_reg, best_next;
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic [1:0]            out_user_reg, out_user_next;

    logic [CNT_W-1:0]      idx_p1;
    logic [CNT_W-1:0]      idx_p2;
    logic                  accept;
    logic [SVC_W-1:0]      in_svc;
    logic [WAIT_W-1:0]     in_wait;
    logic [WAIT_W:0]       wait_sum;
    logic                  sel_ok;

    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    slot_t                 wr_data;
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    slot_t                 rd_data;
    ratio_ctl_t            ratio_ctl;
    logic                  ratio_gt;

    hrrn_slot_mem #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    hrrn_ratio_unit u_ratio (
        .clk       (clk),
        .ctl       (ratio_ctl),
        .cur_wait  (cur_reg.wait_val),
        .cur_svc   (cur_reg.svc_time),
        .best_wait (best_reg.wait_val),
        .best_svc  (best_reg.svc_time),
        .gt        (ratio_gt)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign in_svc   = s_tdata[31:16];
    assign in_wait  = s_tdata[55:32];
    assign idx_p1   = idx_reg + 1'b1;
    assign idx_p2   = idx_reg + 2'd2;
    assign wait_sum = {1'b0, rd_data.wait_val} + (WAIT_W + 1)'(secs_reg);
    assign sel_ok   = (cmd_reg == CMD_SELECT) && (status_reg == ST_OK);

    always_comb
    begin
        state_next     = state_reg;
        occ_next       = occ_reg;
        idx_next       = idx_reg;
        cmd_next       = cmd_reg;
        pid_next       = pid_reg;
        secs_next      = secs_reg;
        status_next    = status_reg;
        cur_next       = cur_reg;
        best_next      = best_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        wr_en          = 1'b0;
        wr_addr        = idx_reg[IDX_W-1:0];
        wr_data        = rd_data;
        rd_en          = 1'b0;
        rd_addr        = '0;
        ratio_ctl      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next    = s_tuser;
                    pid_next    = s_tdata[15:0];
                    secs_next   = s_tdata[71:56];
                    status_next = ST_OK;
                    idx_next    = '0;
                    state_next  = S_DONE;
                    case (s_tuser)
                        CMD_PUSH:
                        begin
                            if (in_svc == '0)
                            begin
                                status_next = ST_ZEROSVC;
                            end
                            else if (occ_reg >= NUM_SLOTS)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                wr_en    = 1'b1;
                                wr_addr  = occ_reg[IDX_W-1:0];
                                wr_data  = '{id: s_tdata[15:0], wait_val: in_wait,
                                             svc_time: in_svc};
                                occ_next = occ_reg + 1'b1;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (occ_reg == '0)
                            begin
                                status_next = ST_NOTFOUND;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                state_next = S_REM_CHK;
                            end
                        end
                        CMD_TICK:
                        begin
                            if (occ_reg != '0)
                            begin
                                rd_en      = 1'b1;
                                state_next = S_TCK_WR;
                            end
                        end
                        default:
                        begin
                            if (occ_reg == '0)
                            begin
                                status_next = ST_NOTFOUND;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                state_next = S_SEL_CUR;
                            end
                        end
                    endcase
                end
            end
            S_REM_CHK:
            begin
                if (rd_data.id == pid_reg)
                begin
                    if (idx_p1 == occ_reg)
                    begin
                        occ_next   = occ_reg - 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = idx_p1[IDX_W-1:0];
                        state_next = S_SH_WR;
                    end
                end
                else if (idx_p1 == occ_reg)
                begin
                    status_next = ST_NOTFOUND;
                    state_next  = S_DONE;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = idx_p1[IDX_W-1:0];
                    idx_next = idx_p1;
                end
            end
            S_SH_WR:
            begin
                // close the gap: slot idx takes the item of slot idx+1
                wr_en = 1'b1;
                if (idx_p2 == occ_reg)
                begin
                    occ_next   = occ_reg - 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = idx_p2[IDX_W-1:0];
                    idx_next = idx_p1;
                end
            end
            S_TCK_WR:
            begin
                wr_en            = 1'b1;
                wr_data.wait_val = wait_sum[WAIT_W] ? WAIT_MAX : wait_sum[WAIT_W-1:0];
                if (idx_p1 == occ_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = idx_p1[IDX_W-1:0];
                    idx_next = idx_p1;
                end
            end
            S_SEL_CUR:
            begin
                cur_next = rd_data;
                if (idx_reg == '0)
                begin
                    best_next = rd_data;
                end
                state_next = S_SEL_LHS;
            end
            S_SEL_LHS:
            begin
                ratio_ctl.load_lhs = 1'b1;
                state_next         = S_SEL_RHS;
            end
            S_SEL_RHS:
            begin
                ratio_ctl.load_rhs = 1'b1;
                state_next         = S_SEL_CMP;
            end
            S_SEL_CMP:
            begin
                // strict compare keeps the earliest item on a tie
                if (ratio_gt)
                begin
                    best_next = cur_reg;
                end
                if (idx_p1 == occ_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = idx_p1[IDX_W-1:0];
                    idx_next   = idx_p1;
                    state_next = S_SEL_CUR;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_user_next  = status_reg;
                    out_data_next  = {2'b00,
                                      sel_ok ? best_reg.svc_time : {SVC_W{1'b0}},
                                      sel_ok ? best_reg.wait_val : {WAIT_W{1'b0}},
                                      sel_ok ? best_reg.id : {ID_W{1'b0}},
                                      (occ_reg == '0),
                                      COUNT_W'(occ_reg)};
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            occ_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        pid_reg      <= pid_next;
        secs_reg     <= secs_next;
        status_reg   <= status_next;
        cur_reg      <= cur_next;
        best_reg     <= best_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= NUM_SLOTS)
        else $error("entry count above slot count");

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (s_tuser == CMD_PUSH) && (in_svc != '0) && (occ_reg < NUM_SLOTS))
        |=> (occ_reg == $past(occ_reg) + 1'b1))
        else $error("accepted push did not grow the queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != ST_OK)) |-> (m_tdata[61:6] == '0))
        else $error("chosen fields not cleared on a failed command");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[5]) |-> (m_tdata[4:0] == '0))
        else $error("empty flag with nonzero entry count");
`endif

endmodule

`default_nettype wire

// ===== sim/tb_hrrn_ready_queue_unit.sv =====
// ----------------------------------------------------------------------------
// tb_hrrn_ready_queue_unit
// self-checking bench for the highest response ratio next ready queue
//
// A shadow queue in the bench tracks every accepted command. It predicts the
// status, the entry count and the chosen entry of each result item. Results
// are checked in order against those predictions. Directed tests cover the
// empty queue, zero service, ties, saturating ticks, duplicates and a full
// queue. Random traffic runs after them, under several idle and stall mixes
// and with a long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_hrrn_ready_queue_unit;

    import hrrn_pkg::*;

    localparam int NUM_SLOTS      = NUM_SLOTS_DEF;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [1:0]         status;
        logic [COUNT_W-1:0] count;
        logic               empty;
        logic [ID_W-1:0]    cid;
        logic [WAIT_W-1:0]  cwait;
        logic [SVC_W-1:0]   csvc;
    } queue_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [1:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [1:0]            m_tuser;

    // shadow copy of the queue contents
    logic [ID_W-1:0]   shadow_id   [NUM_SLOTS];
    logic [WAIT_W-1:0] shadow_wait [NUM_SLOTS];
    logic [SVC_W-1:0]  shadow_svc  [NUM_SLOTS];
    int                shadow_count;

    queue_result_t pending_results[$];

    int send_idle_pct;
    int recv_stall_pct;
    int hold_cycles;
    int idle_run;
    int mismatch_count;
    int results_checked;
    int items_sent;
    int n_push_ok;
    int n_full;
    int n_zero_svc;
    int n_not_found;
    int n_select_ok;
    int n_saturated;

    hrrn_ready_queue_unit #(
        .NUM_SLOTS (NUM_SLOTS)
    )
    dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    function automatic queue_result_t apply_queue_command(
        input logic [1:0]        cmd,
        input logic [ID_W-1:0]   pid,
        input logic [SVC_W-1:0]  svc,
        input logic [WAIT_W-1:0] wt,
        input logic [SECS_W-1:0] secs
    );
        queue_result_t    r;
        int               i;
        int               pos;
        int               best;
        longint unsigned  lhs;
        longint unsigned  rhs;
        longint unsigned  sum;
        r = '0;
        r.status = ST_OK;
        case (cmd)
            CMD_PUSH:
            begin
                if (svc == '0)
                begin
                    r.status = ST_ZEROSVC;
                    n_zero_svc++;
                end
                else if (shadow_count >= NUM_SLOTS)
                begin
                    r.status = ST_FULL;
                    n_full++;
                end
                else
                begin
                    shadow_id[shadow_count]   = pid;
                    shadow_wait[shadow_count] = wt;
                    shadow_svc[shadow_count]  = svc;
                    shadow_count++;
                    n_push_ok++;
                end
            end
            CMD_REMOVE:
            begin
                pos = -1;
                for (i = 0; i < shadow_count; i++)
                    if (pos < 0 && shadow_id[i] == pid)
                        pos = i;
                if (pos < 0)
                begin
                    r.status = ST_NOTFOUND;
                    n_not_found++;
                end
                else
                begin
                    for (i = pos; i + 1 < shadow_count; i++)
                    begin
                        shadow_id[i]   = shadow_id[i+1];
                        shadow_wait[i] = shadow_wait[i+1];
                        shadow_svc[i]  = shadow_svc[i+1];
                    end
                    shadow_count--;
                end
            end
            CMD_TICK:
            begin
                for (i = 0; i < shadow_count; i++)
                begin
                    sum = longint'(shadow_wait[i]) + longint'(secs);
                    if (sum > longint'(WAIT_MAX))
                    begin
                        shadow_wait[i] = WAIT_MAX;
                        n_saturated++;
                    end
                    else
                        shadow_wait[i] = sum[WAIT_W-1:0];
                end
            end
            default:
            begin
                if (shadow_count == 0)
                begin
                    r.status = ST_NOTFOUND;
                    n_not_found++;
                end
                else
                begin
                    // exact ratio compare by cross products, earliest wins ties
                    best = 0;
                    for (i = 1; i < shadow_count; i++)
                    begin
                        lhs = longint'(shadow_wait[i]) * longint'(shadow_svc[best]);
                        rhs = longint'(shadow_wait[best]) * longint'(shadow_svc[i]);
                        if (lhs > rhs)
                            best = i;
                    end
                    r.cid   = shadow_id[best];
                    r.cwait = shadow_wait[best];
                    r.csvc  = shadow_svc[best];
                    n_select_ok++;
                end
            end
        endcase
        r.count = shadow_count[COUNT_W-1:0];
        r.empty = (shadow_count == 0);
        return r;
    endfunction

    task automatic check_result(input queue_result_t act);
        queue_result_t exp_r;
        if (pending_results.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("result item with no command pending: status %0d count %0d",
                         act.status, act.count);
        end
        else
        begin
            exp_r = pending_results.pop_front();
            results_checked++;
            if (act.status !== exp_r.status || act.count !== exp_r.count ||
                act.empty !== exp_r.empty || act.cid !== exp_r.cid ||
                act.cwait !== exp_r.cwait || act.csvc !== exp_r.csvc)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                begin
                    $display("mismatch at result %0d", results_checked);
                    $display("  expected status %0d count %0d empty %0d id %h wait %h svc %h",
                             exp_r.status, exp_r.count, exp_r.empty,
                             exp_r.cid, exp_r.cwait, exp_r.csvc);
                    $display("  actual   status %0d count %0d empty %0d id %h wait %h svc %h",
                             act.status, act.count, act.empty,
                             act.cid, act.cwait, act.csvc);
                end
            end
        end
    endtask

    // monitor: predict on input accept, check on output accept
    always @(posedge clk)
    begin
        queue_result_t act;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                act.status = m_tuser;
                act.count  = m_tdata[4:0];
                act.empty  = m_tdata[5];
                act.cid    = m_tdata[21:6];
                act.cwait  = m_tdata[45:22];
                act.csvc   = m_tdata[61:46];
                check_result(act);
            end
            if (s_tvalid && s_tready)
                pending_results.push_back(apply_queue_command(
                    s_tuser, s_tdata[15:0], s_tdata[31:16],
                    s_tdata[55:32], s_tdata[71:56]));
        end
    end

    // watchdog on cycles without any accepted item
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_run = 0;
            else
                idle_run++;
            if (idle_run >= WATCHDOG_LIMIT)
            begin
                $display("watchdog expired, %0d results outstanding",
                         pending_results.size());
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // receiver: random stalls plus an optional long hold-off
    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                hold_cycles--;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_item(
        input logic [1:0]        cmd,
        input logic [ID_W-1:0]   pid,
        input logic [SVC_W-1:0]  svc,
        input logic [WAIT_W-1:0] wt,
        input logic [SECS_W-1:0] secs
    );
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {secs, wt, svc, pid};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_random_command(input int push_weight);
        logic [1:0]        cmd;
        logic [ID_W-1:0]   pid;
        logic [SVC_W-1:0]  svc;
        logic [WAIT_W-1:0] wt;
        logic [SECS_W-1:0] secs;
        int                roll;
        if ($urandom_range(99) < push_weight)
            cmd = CMD_PUSH;
        else
        begin
            roll = $urandom_range(2);
            cmd = (roll == 0) ? CMD_REMOVE : (roll == 1) ? CMD_TICK : CMD_SELECT;
        end
        pid = ID_W'($urandom);
        if ($urandom_range(1))
            pid = ID_W'($urandom_range(7));
        if (cmd == CMD_REMOVE && shadow_count > 0 && $urandom_range(3) != 0)
            pid = shadow_id[$urandom_range(shadow_count - 1)];
        roll = $urandom_range(99);
        if (roll < 5)
            svc = '0;
        else if (roll < 15)
            svc = '1;
        else if (roll < 55)
            svc = SVC_W'($urandom_range(255, 1));
        else
            svc = SVC_W'($urandom);
        wt = WAIT_W'($urandom);
        if ($urandom_range(4) == 0)
            wt = WAIT_MAX - WAIT_W'($urandom_range(255));
        roll = $urandom_range(9);
        if (roll < 2)
            secs = SECS_W'($urandom_range(15));
        else if (roll == 2)
            secs = '1;
        else
            secs = SECS_W'($urandom);
        send_item(cmd, pid, svc, wt, secs);
    endtask

    task automatic test_empty_queue();
        send_item(CMD_SELECT, 16'h1234, 16'h0001, 24'h000001, 16'h0001);
        send_item(CMD_REMOVE, 16'h0000, 16'h0001, 24'h000000, 16'h0000);
        send_item(CMD_TICK,   16'h0000, 16'h0000, 24'h000000, 16'hFFFF);
        send_item(CMD_PUSH,   16'h00AA, 16'h0000, 24'h000010, 16'h0000);
        wait_for_results();
    endtask

    task automatic test_ties_and_saturation();
        send_item(CMD_PUSH,   16'hFFFF, 16'hFFFF, 24'hFFFFFF, 16'h0000);
        send_item(CMD_PUSH,   16'h0000, 16'h0001, 24'h000000, 16'h0000);
        send_item(CMD_PUSH,   16'hFFFF, 16'h0001, 24'h000000, 16'h0000);
        send_item(CMD_SELECT, 16'h0000, 16'h0000, 24'h000000, 16'h0000);
        send_item(CMD_TICK,   16'h0000, 16'h0000, 24'h000000, 16'hFFFF);
        send_item(CMD_SELECT, 16'h0000, 16'h0000, 24'h000000, 16'h0000);
        // duplicate id, the earliest match goes
        send_item(CMD_REMOVE, 16'hFFFF, 16'h0000, 24'h000000, 16'h0000);
        send_item(CMD_SELECT, 16'h0000, 16'h0000, 24'h000000, 16'h0000);
        send_item(CMD_REMOVE, 16'h7777, 16'h0000, 24'h000000, 16'h0000);
        wait_for_results();
    endtask

    task automatic test_full_queue();
        int n;
        n = shadow_count;
        while (n < NUM_SLOTS)
        begin
            send_item(CMD_PUSH, 16'(n + 1), 16'(n + 2), 24'(n * 3), 16'h0000);
            n++;
        end
        send_item(CMD_PUSH,   16'h0BAD, 16'h0005, 24'h000005, 16'h0000);
        send_item(CMD_PUSH,   16'h0BAD, 16'h0000, 24'h000005, 16'h0000);
        send_item(CMD_SELECT, 16'h0000, 16'h0000, 24'h000000, 16'h0000);
        wait_for_results();
    endtask

    task automatic test_random_traffic(input int n_items, input int idle_pct,
                                       input int stall_pct);
        int k;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        // alternate push-heavy and drain-heavy stretches
        for (k = 0; k < n_items; k++)
            send_random_command(((k / 40) % 2 == 0) ? 65 : 20);
        wait_for_results();
    endtask

    task automatic test_output_hold_off();
        int k;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 300;
        for (k = 0; k < 24; k++)
            send_random_command(50);
        wait_for_results();
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        s_tvalid       <= 1'b0;
        s_tdata        <= '0;
        s_tuser        <= CMD_PUSH;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_cycles     = 0;
        idle_run        = 0;
        mismatch_count  = 0;
        results_checked = 0;
        items_sent      = 0;
        shadow_count    = 0;
        n_push_ok       = 0;
        n_full          = 0;
        n_zero_svc      = 0;
        n_not_found     = 0;
        n_select_ok     = 0;
        n_saturated     = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_queue();
        test_ties_and_saturation();
        test_full_queue();
        test_random_traffic(340, 0, 0);
        test_random_traffic(340, 53, 0);
        test_output_hold_off();
        test_random_traffic(340, 0, 53);
        test_random_traffic(340, 26, 26);

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        if (pending_results.size() != 0)
            mismatch_count++;

        $display("%0d items sent, %0d results checked, %0d selects with an entry",
                 items_sent, results_checked, n_select_ok);
        $display("%0d pushes stored, %0d full, %0d zero service, %0d not found, %0d saturated",
                 n_push_ok, n_full, n_zero_svc, n_not_found, n_saturated);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
